// File: hw/rtl/lss_pkg.sv
package lss_pkg;

   localparam int StackDepth = 16;
   localparam int AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
   localparam int CntW       = $clog2(StackDepth + 1);
   localparam int WordW      = 32;
   localparam int LenW       = 5;
   localparam int KindW      = 2;
   localparam int StatusW    = 2;

   localparam logic [WordW-1:0] EmptyWord = '1;

   typedef enum logic [KindW-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_PEEK = 2'd2,
      KIND_SORT = 2'd3
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // datapath operation for the current cycle
   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_PUSH       = 4'd1,
      OP_POP        = 4'd2,
      OP_READ_TOP   = 4'd3,
      OP_EMPTY_RSP  = 4'd4,
      OP_DATA_RSP   = 4'd5,
      OP_SORT_INIT  = 4'd6,
      OP_PASS_START = 4'd7,
      OP_LOAD       = 4'd8,
      OP_CMP        = 4'd9,
      OP_PASS_END   = 4'd10
   } dp_op_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic hi_zero;
      logic idx_last;
   } dp_status_type;

endpackage

// File: hw/rtl/lss_ram.sv
module lss_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
   input  logic [Width-1:0]               wr_data,
   input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
   output logic [Width-1:0]               rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lss_ctrl.sv
module lss_ctrl
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KindW-1:0]    req_kind,
   input  dp_status_type       dp_status,
   output logic                busy,
   output dp_op_type           dp_op
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_PASS = 6'b000100,
      ST_LOAD = 6'b001000,
      ST_CMP  = 6'b010000,
      ST_END  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind;

   assign kind = kind_type'(req_kind);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dp_op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind)
                  KIND_PUSH: begin
                     dp_op = OP_PUSH;
                  end
                  KIND_POP: begin
                     if (dp_status.empty) begin
                        dp_op = OP_EMPTY_RSP;
                     end else begin
                        dp_op    = OP_POP;
                        state_in = ST_RD;
                     end
                  end
                  KIND_PEEK: begin
                     if (dp_status.empty) begin
                        dp_op = OP_EMPTY_RSP;
                     end else begin
                        dp_op    = OP_READ_TOP;
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     if (dp_status.empty) begin
                        dp_op = OP_EMPTY_RSP;
                     end else begin
                        dp_op    = OP_SORT_INIT;
                        state_in = ST_PASS;
                     end
                  end
               endcase
            end
         end
         ST_RD: begin
            dp_op    = OP_DATA_RSP;
            state_in = ST_IDLE;
         end
         ST_PASS: begin
            // last pass done: fetch the new top for the result
            if (dp_status.hi_zero) begin
               dp_op    = OP_READ_TOP;
               state_in = ST_RD;
            end else begin
               dp_op    = OP_PASS_START;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dp_op    = OP_LOAD;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            dp_op = OP_CMP;
            if (dp_status.idx_last) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            dp_op    = OP_PASS_END;
            state_in = ST_PASS;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/lss_datapath.sv
module lss_datapath
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_op_type           dp_op,
   input  logic [WordW-1:0]    req_value,
   output dp_status_type       dp_status,
   output logic                ram_wr_en,
   output logic [AddrW-1:0]    ram_wr_addr,
   output logic [WordW-1:0]    ram_wr_data,
   output logic [AddrW-1:0]    ram_rd_addr,
   input  logic [WordW-1:0]    ram_rd_data,
   output logic                rsp_strobe,
   output logic [WordW-1:0]    rsp_result_value,
   output logic [LenW-1:0]     rsp_length,
   output logic [StatusW-1:0]  rsp_status
);

   logic [CntW-1:0]    count_ff, count_in;
   logic [AddrW-1:0]   hi_ff, hi_in;
   logic [AddrW-1:0]   idx_ff, idx_in;
   logic [WordW-1:0]   carry_ff, carry_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [WordW-1:0]   rsp_value_ff, rsp_value_in;
   logic [LenW-1:0]    rsp_length_ff, rsp_length_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               empty;
   logic               full;
   logic [AddrW-1:0]   top_addr;
   logic               data_less;
   logic [WordW-1:0]   larger;
   logic [WordW-1:0]   smaller;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(StackDepth));
   assign top_addr = AddrW'(count_ff - CntW'(1));

   // signed compare of the fetched entry against the running minimum
   assign data_less = ($signed(ram_rd_data) < $signed(carry_ff));
   assign larger    = data_less ? carry_ff : ram_rd_data;
   assign smaller   = data_less ? ram_rd_data : carry_ff;

   assign dp_status.empty    = empty;
   assign dp_status.full     = full;
   assign dp_status.hi_zero  = (hi_ff == '0);
   assign dp_status.idx_last = (idx_ff == hi_ff);

   always_comb begin
      count_in      = count_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = carry_ff;
      ram_rd_addr   = '0;
      case (dp_op)
         OP_PUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            if (full) begin
               rsp_status_in = STATUS_FULL;
               rsp_length_in = LenW'(count_ff);
            end else begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = AddrW'(count_ff);
               ram_wr_data   = req_value;
               count_in      = count_ff + CntW'(1);
               rsp_status_in = STATUS_OK;
               rsp_length_in = LenW'(count_ff + CntW'(1));
            end
         end
         OP_POP: begin
            ram_rd_addr = top_addr;
            count_in    = count_ff - CntW'(1);
         end
         OP_READ_TOP: begin
            ram_rd_addr = top_addr;
         end
         OP_EMPTY_RSP: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = EmptyWord;
            rsp_length_in = LenW'(count_ff);
            rsp_status_in = STATUS_EMPTY;
         end
         OP_DATA_RSP: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = ram_rd_data;
            rsp_length_in = LenW'(count_ff);
            rsp_status_in = STATUS_OK;
         end
         OP_SORT_INIT: begin
            hi_in = top_addr;
         end
         OP_PASS_START: begin
            ram_rd_addr = '0;
            idx_in      = AddrW'(1);
         end
         OP_LOAD: begin
            carry_in    = ram_rd_data;
            ram_rd_addr = idx_ff;
         end
         OP_CMP: begin
            // larger word sinks one place, the minimum rides toward the top
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff - AddrW'(1);
            ram_wr_data = larger;
            carry_in    = smaller;
            idx_in      = idx_ff + AddrW'(1);
            ram_rd_addr = idx_ff + AddrW'(1);
         end
         OP_PASS_END: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi_ff;
            ram_wr_data = carry_ff;
            hi_in       = hi_ff - AddrW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      carry_ff      <= carry_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_length       = rsp_length_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: hw/rtl/lifo_stack_with_sort_core.sv
// push, and any request on an empty stack: result in the cycle after start, next start at once
// pop and peek: one ram read, busy in the read state, result in the same cycle as busy falls
// sort of n entries: n-1 bubble passes through the ram's single read port and single write port,
// busy until the new top is read back, result in the same cycle as busy falls
// reset clears the length and the control state; stack words stay undefined until pushed
// rsp_strobe is high for one cycle per result; the receiver cannot stall
module lifo_stack_with_sort_core
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KindW-1:0]    req_kind,
   input  logic [WordW-1:0]    req_value,
   output logic                rsp_strobe,
   output logic [WordW-1:0]    rsp_result_value,
   output logic [LenW-1:0]     rsp_length,
   output logic [StatusW-1:0]  rsp_status
);

   dp_op_type      dp_op;
   dp_status_type  dp_status;
   logic           ram_wr_en;
   logic [AddrW-1:0] ram_wr_addr;
   logic [WordW-1:0] ram_wr_data;
   logic [AddrW-1:0] ram_rd_addr;
   logic [WordW-1:0] ram_rd_data;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .dp_status (dp_status),
      .busy      (busy),
      .dp_op     (dp_op)
   );

   lss_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_op            (dp_op),
      .req_value        (req_value),
      .dp_status        (dp_status),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_length       (rsp_length),
      .rsp_status       (rsp_status)
   );

   lss_ram #(
      .Width (WordW),
      .Depth (StackDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// File: tb/lifo_sort_checker.sv
module lifo_sort_checker
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [KindW-1:0]    req_kind,
   input  logic [WordW-1:0]    req_value,
   input  logic                rsp_strobe,
   input  logic [WordW-1:0]    rsp_result_value,
   input  logic [LenW-1:0]     rsp_length,
   input  logic [StatusW-1:0]  rsp_status,
   output int                  fail_count,
   output int                  outstanding,
   output int                  reply_count,
   output int                  sort_count,
   output int                  full_count,
   output int                  empty_count
);

   typedef struct packed {
      logic [WordW-1:0]   value;
      logic [LenW-1:0]    length;
      logic [StatusW-1:0] status;
   } reply_type;

   logic signed [WordW-1:0] stack_words [StackDepth];
   int                      stack_fill;
   reply_type               awaited_replies [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      reply_count = 0;
      sort_count  = 0;
      full_count  = 0;
      empty_count = 0;
      stack_fill  = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // bottom holds the largest word, top the smallest
   task automatic sort_stack_words();
      int                      i;
      int                      j;
      logic signed [WordW-1:0] key;
      for (i = 1; i < stack_fill; i++) begin
         key = stack_words[i];
         j = i;
         while (j > 0 && stack_words[j-1] < key) begin
            stack_words[j] = stack_words[j-1];
            j--;
         end
         stack_words[j] = key;
      end
   endtask

   task automatic apply_stack_request(input kind_type kind, input logic [WordW-1:0] word,
                                      output reply_type reply);
      reply.value  = '0;
      reply.status = STATUS_OK;
      case (kind)
         KIND_PUSH: begin
            if (stack_fill < StackDepth) begin
               stack_words[stack_fill] = word;
               stack_fill++;
            end else begin
               reply.status = STATUS_FULL;
               full_count++;
            end
         end
         KIND_POP: begin
            if (stack_fill == 0) begin
               reply.value  = EmptyWord;
               reply.status = STATUS_EMPTY;
               empty_count++;
            end else begin
               stack_fill--;
               reply.value = stack_words[stack_fill];
            end
         end
         KIND_PEEK: begin
            if (stack_fill == 0) begin
               reply.value  = EmptyWord;
               reply.status = STATUS_EMPTY;
               empty_count++;
            end else begin
               reply.value = stack_words[stack_fill-1];
            end
         end
         default: begin
            sort_count++;
            if (stack_fill == 0) begin
               reply.value  = EmptyWord;
               reply.status = STATUS_EMPTY;
               empty_count++;
            end else begin
               sort_stack_words();
               reply.value = stack_words[stack_fill-1];
            end
         end
      endcase
      reply.length = stack_fill[LenW-1:0];
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         stack_fill = 0;
         awaited_replies.delete();
      end else begin
         // a result always belongs to a transfer from an earlier edge
         if (rsp_strobe) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch($sformatf("result %0h with nothing awaited", rsp_result_value));
            end else begin
               want = awaited_replies.pop_front();
               reply_count++;
               if (rsp_result_value !== want.value)
                  report_mismatch($sformatf("value got %0h expected %0h",
                                            rsp_result_value, want.value));
               if (rsp_length !== want.length)
                  report_mismatch($sformatf("length got %0d expected %0d",
                                            rsp_length, want.length));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (start && !busy) begin
            apply_stack_request(kind_type'(req_kind), req_value, want);
            awaited_replies.push_back(want);
         end
      end
      outstanding = awaited_replies.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   import lss_pkg::*;

   typedef enum int {
      SEG_FILL,
      SEG_DRAIN,
      SEG_MIXED
   } segment_mode_type;

   localparam int RandomItems = 1825;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [KindW-1:0]   req_kind = KIND_PUSH;
   logic [WordW-1:0]   req_value = '0;
   logic               rsp_strobe;
   logic [WordW-1:0]   rsp_result_value;
   logic [LenW-1:0]    rsp_length;
   logic [StatusW-1:0] rsp_status;

   int fail_count;
   int outstanding;
   int reply_count;
   int sort_count;
   int full_count;
   int empty_count;
   int issued = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lifo_stack_with_sort_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_length       (rsp_length),
      .rsp_status       (rsp_status)
   );

   lifo_sort_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_length       (rsp_length),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .reply_count      (reply_count),
      .sort_count       (sort_count),
      .full_count       (full_count),
      .empty_count      (empty_count)
   );

   // one transfer; start stays high across back-to-back items
   task automatic issue(input kind_type kind, input logic [WordW-1:0] word, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      do @(posedge clock); while (busy);
      issued++;
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [WordW-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom;
      // small values repeat often, so sorts see duplicates
      if (r < 80) return WordW'($signed($urandom_range(0, 7)) - 4);
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h8000_0001;
         default: return 32'h7fff_fffe;
      endcase
   endfunction

   function automatic kind_type pick_kind(input segment_mode_type mode);
      int r;
      int push_lim;
      int pop_lim;
      r = $urandom_range(0, 99);
      case (mode)
         SEG_FILL:  begin push_lim = 70; pop_lim = 80; end
         SEG_DRAIN: begin push_lim = 20; pop_lim = 75; end
         default:   begin push_lim = 45; pop_lim = 75; end
      endcase
      if (r < push_lim) return KIND_PUSH;
      if (r < pop_lim) return KIND_POP;
      if (r < 91) return KIND_PEEK;
      return KIND_SORT;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int               k;
      int               seg;
      int               seg_len;
      int               random_done;
      int               waited;
      bit               no_gaps;
      segment_mode_type mode;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty stack cases
      issue(KIND_POP, $urandom, 0);
      issue(KIND_PEEK, $urandom, 1);
      issue(KIND_SORT, $urandom, 0);
      // word extremes, then sort them and take the minimum back off
      issue(KIND_PUSH, 32'h7fff_ffff, 0);
      issue(KIND_PUSH, 32'h8000_0000, 0);
      issue(KIND_PUSH, 32'h0000_0000, 2);
      issue(KIND_PUSH, 32'hffff_ffff, 0);
      issue(KIND_PEEK, $urandom, 0);
      issue(KIND_SORT, $urandom, 0);
      issue(KIND_POP, $urandom, 0);
      // fill to the limit, overflow once, sort a full stack
      for (k = 0; k < StackDepth - 3; k++) issue(KIND_PUSH, pick_word(), 0);
      issue(KIND_PUSH, $urandom, 0);
      issue(KIND_SORT, $urandom, 0);

      random_done = 0;
      seg = 0;
      while (random_done < RandomItems) begin
         seg_len = $urandom_range(10, 40);
         mode    = segment_mode_type'($urandom_range(0, 2));
         no_gaps = ($urandom_range(0, 3) == 0);
         if (seg == 30 || $urandom_range(0, 9) == 0) wait_until_drained();
         for (k = 0; k < seg_len && random_done < RandomItems; k++) begin
            issue(pick_kind(mode), pick_word(), no_gaps ? 0 : pick_gap());
            random_done++;
         end
         seg++;
      end

      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);

      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      $display("%0d requests sent, %0d results compared", issued, reply_count);
      $display("%0d sorts, %0d pushes into a full stack, %0d requests on an empty stack",
               sort_count, full_count, empty_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("tb NOT OK");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_ram.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lss_datapath.sv
hw/rtl/lifo_stack_with_sort_core.sv
tb/lifo_sort_checker.sv
tb/tb.sv
